// ===== rtl/i2cbm_pkg.sv =====
package i2cbm_pkg;

  localparam int unsigned UNIT_W = 16;
  localparam int unsigned POLL_W = 8;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [UNIT_W-1:0] UNIT_TICKS_RST  = 16'd50;
  localparam logic [POLL_W-1:0] ACK_TIMEOUT_RST = 8'd255;

  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_TICKS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'd1;

  localparam logic [2:0] FN_START     = 3'd0;
  localparam logic [2:0] FN_STOP      = 3'd1;
  localparam logic [2:0] FN_WRITE     = 3'd2;
  localparam logic [2:0] FN_READ      = 3'd3;
  localparam logic [2:0] FN_WAIT_ACK  = 3'd4;
  localparam logic [2:0] FN_SEND_ACK  = 3'd5;
  localparam logic [2:0] FN_SEND_NACK = 3'd6;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] func;
    logic [7:0] wr_data;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rd_data;
    logic       ack_ok;
  } res_t;

endpackage

// ===== rtl/i2cbm_in_stage.sv =====
module i2cbm_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  i2cbm_pkg::item_t  in_item,
  input  logic              out_rdy,
  output logic              proc_en,
  output i2cbm_pkg::item_t  item_r
);

  logic vld_r;
  logic vld_nxt;
  logic accept;

  assign proc_en  = vld_r && out_rdy;
  assign in_stall = vld_r && !out_rdy;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (proc_en) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== rtl/i2cbm_seq.sv =====
module i2cbm_seq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [i2cbm_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [i2cbm_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                                proc_en,
  input  i2cbm_pkg::item_t                    item,
  output i2cbm_pkg::res_t                     res
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'd0,
    ST_START0 = 5'd1,  ST_START1 = 5'd2,  ST_START2 = 5'd3,  ST_START3 = 5'd4,
    ST_STOP0  = 5'd5,  ST_STOP1  = 5'd6,  ST_STOP2  = 5'd7,  ST_STOP3  = 5'd8,
    ST_STOP4  = 5'd9,  ST_STOP5  = 5'd10,
    ST_WR0    = 5'd11, ST_WR1    = 5'd12, ST_WR2    = 5'd13, ST_WR3    = 5'd14,
    ST_RD0    = 5'd15, ST_RD1    = 5'd16, ST_RD2    = 5'd17, ST_RD3    = 5'd18,
    ST_AW0    = 5'd19, ST_AW1    = 5'd20, ST_AW2    = 5'd21, ST_AW3    = 5'd22,
    ST_SA0    = 5'd23, ST_SA1    = 5'd24, ST_SA2    = 5'd25, ST_SA3    = 5'd26,
    ST_SA4    = 5'd27, ST_SA5    = 5'd28,
    ST_SN0    = 5'd29, ST_SN1    = 5'd30
  } step_t;

  typedef struct packed {
    step_t                         step;
    logic [i2cbm_pkg::UNIT_W-1:0]  ucnt;
    logic [3:0]                    bcnt;
    logic [7:0]                    shb;
    logic [i2cbm_pkg::POLL_W-1:0]  pcnt;
    logic                          scl;
    logic                          sda;
    logic                          ack;
    logic [7:0]                    rhold;
    logic                          done;
  } st_t;

  logic [i2cbm_pkg::UNIT_W-1:0] unit_ticks_r;
  logic [i2cbm_pkg::POLL_W-1:0] ack_timeout_r;
  logic [i2cbm_pkg::UNIT_W-1:0] eff_unit;
  st_t st_r;
  st_t st_nxt;

  assign eff_unit = (unit_ticks_r == '0) ? i2cbm_pkg::UNIT_W'(1) : unit_ticks_r;

  function automatic st_t finish(st_t s0);
    st_t s;
    s      = s0;
    s.step = ST_IDLE;
    s.ucnt = '0;
    s.done = 1'b1;
    return s;
  endfunction

  function automatic st_t enter(st_t s0, step_t nx, logic sda_i,
                                logic [i2cbm_pkg::UNIT_W-1:0] eff);
    st_t s;
    logic [i2cbm_pkg::POLL_W-1:0] pn;
    s      = s0;
    s.step = nx;
    s.ucnt = eff;
    pn     = (s0.pcnt != '0) ? s0.pcnt - 1'b1 : s0.pcnt;
    case (nx)
      ST_START0: begin s.scl = 1'b1; s.sda = 1'b1; end
      ST_START2: s.sda = 1'b0;
      ST_STOP0:  s.sda = 1'b0;
      ST_STOP2:  s.scl = 1'b1;
      ST_STOP4:  s.sda = 1'b1;
      ST_WR0: begin
        s.scl = 1'b0;
        s.sda = s0.shb[7];
        s.shb = {s0.shb[6:0], 1'b0};
      end
      ST_WR2:    s.scl = 1'b1;
      ST_RD0:    s.scl = 1'b0;
      ST_RD2: begin
        s.scl = 1'b1;
        s.shb = {s0.shb[6:0], sda_i};
      end
      ST_AW0:    s.sda = 1'b1;
      ST_AW1:    s.scl = 1'b0;
      ST_AW2:    s.scl = 1'b1;
      ST_AW3: begin
        if (!sda_i) begin
          s.scl = 1'b0;
          s.ack = 1'b1;
          s     = finish(s);
        end else begin
          s.pcnt = pn;
          if (pn == '0) begin
            // timeout: fall into the stop sequence
            s.ack  = 1'b0;
            s.sda  = 1'b0;
            s.step = ST_STOP0;
          end
        end
      end
      ST_SA0:    s.sda = 1'b0;
      ST_SA2:    s.scl = 1'b1;
      ST_SA4:    s.scl = 1'b0;
      ST_SN0:    s.sda = 1'b1;
      default: ;
    endcase
    return s;
  endfunction

  always_comb begin
    logic [i2cbm_pkg::UNIT_W-1:0] ud;
    logic [3:0]                   bn;
    st_nxt      = st_r;
    st_nxt.done = 1'b0;
    ud          = (st_r.ucnt != '0) ? st_r.ucnt - 1'b1 : st_r.ucnt;
    bn          = st_r.bcnt + 4'd1;
    if (st_r.step == ST_IDLE) begin
      if (item.cmd_valid) begin
        case (item.func)
          i2cbm_pkg::FN_START: st_nxt = enter(st_nxt, ST_START0, item.sda_in, eff_unit);
          i2cbm_pkg::FN_STOP:  st_nxt = enter(st_nxt, ST_STOP0, item.sda_in, eff_unit);
          i2cbm_pkg::FN_WRITE: begin
            st_nxt.shb  = item.wr_data;
            st_nxt.bcnt = '0;
            st_nxt      = enter(st_nxt, ST_WR0, item.sda_in, eff_unit);
          end
          i2cbm_pkg::FN_READ: begin
            st_nxt.sda  = 1'b1;
            st_nxt.shb  = '0;
            st_nxt.bcnt = '0;
            st_nxt      = enter(st_nxt, ST_RD0, item.sda_in, eff_unit);
          end
          i2cbm_pkg::FN_WAIT_ACK: begin
            st_nxt.pcnt = (ack_timeout_r == '0) ? i2cbm_pkg::POLL_W'(1) : ack_timeout_r;
            st_nxt      = enter(st_nxt, ST_AW0, item.sda_in, eff_unit);
          end
          i2cbm_pkg::FN_SEND_ACK:  st_nxt = enter(st_nxt, ST_SA0, item.sda_in, eff_unit);
          i2cbm_pkg::FN_SEND_NACK: st_nxt = enter(st_nxt, ST_SN0, item.sda_in, eff_unit);
          default: ;
        endcase
      end
    end else begin
      st_nxt.ucnt = ud;
      if (ud == '0) begin
        case (st_r.step)
          ST_START3, ST_STOP5: st_nxt = finish(st_nxt);
          ST_WR3: begin
            st_nxt.bcnt = bn;
            if (bn >= 4'd8) begin
              st_nxt.scl = 1'b0;
              st_nxt     = finish(st_nxt);
            end else begin
              st_nxt = enter(st_nxt, ST_WR0, item.sda_in, eff_unit);
            end
          end
          ST_RD3: begin
            st_nxt.bcnt = bn;
            if (bn >= 4'd8) begin
              st_nxt.scl   = 1'b0;
              st_nxt.rhold = st_r.shb;
              st_nxt       = finish(st_nxt);
            end else begin
              st_nxt = enter(st_nxt, ST_RD0, item.sda_in, eff_unit);
            end
          end
          ST_AW3: st_nxt = enter(st_nxt, ST_AW3, item.sda_in, eff_unit);
          ST_SA5: begin
            st_nxt.sda = 1'b1;
            st_nxt     = finish(st_nxt);
          end
          ST_SN1: st_nxt = enter(st_nxt, ST_SA2, item.sda_in, eff_unit);
          default: st_nxt = enter(st_nxt, step_t'(st_r.step + 5'd1), item.sda_in, eff_unit);
        endcase
      end
    end
  end

  assign res.scl     = st_nxt.scl;
  assign res.sda     = st_nxt.sda;
  assign res.busy    = (st_nxt.step != ST_IDLE);
  assign res.done    = st_nxt.done;
  assign res.rd_data = st_nxt.rhold;
  assign res.ack_ok  = st_nxt.ack;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.step  <= ST_IDLE;
      st_r.ucnt  <= '0;
      st_r.bcnt  <= '0;
      st_r.shb   <= '0;
      st_r.pcnt  <= '0;
      st_r.scl   <= 1'b1;
      st_r.sda   <= 1'b1;
      st_r.ack   <= 1'b0;
      st_r.rhold <= '0;
      st_r.done  <= 1'b0;
    end else if (proc_en) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_ticks_r  <= i2cbm_pkg::UNIT_TICKS_RST;
      ack_timeout_r <= i2cbm_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx)
        i2cbm_pkg::CFG_UNIT_TICKS:  unit_ticks_r  <= cfg_wdata;
        i2cbm_pkg::CFG_ACK_TIMEOUT: ack_timeout_r <= cfg_wdata[i2cbm_pkg::POLL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/i2cbm_out_stage.sv =====
module i2cbm_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             proc_en,
  input  i2cbm_pkg::res_t  res,
  output logic             out_rdy,
  output logic             out_valid,
  input  logic             out_stall,
  output i2cbm_pkg::res_t  res_r
);

  logic vld_r;
  logic vld_nxt;

  assign out_rdy   = !vld_r || !out_stall;
  assign out_valid = vld_r;

  always_comb begin
    vld_nxt = vld_r;
    if (proc_en) begin
      vld_nxt = 1'b1;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_en) begin
      res_r <= res;
    end
  end

endmodule

// ===== rtl/i2c_bit_master.sv =====
// Bit-level I2C master, stepped once per input transfer (one bus tick each).
// Input channel: in_valid/in_stall with in_cmd_valid, in_func, in_wr_data and
// in_sda_in. A command is taken only while idle; otherwise it is ignored.
// Result channel: out_valid/out_stall carries one result per input transfer:
// SCL/SDA drives, busy, done, last read byte and last acknowledge status.
// Config: cfg_wr_en/cfg_idx/cfg_wdata; index 0 unit_ticks, 1 ack_timeout.
// Write config only while idle with all results drained.
// Each input transfer is captured in the input register; its result then goes
// through one pass of sequencer logic into the output register.
// Throughput: one transfer per cycle while out_stall holds no result; the
// sequencer steps once per transfer, between the two registers.
// Reset (rst_n low, synchronous): idle, both lines released, counters and
// read byte cleared, unit_ticks 50, ack_timeout 255.
// When out_stall is high the result holds; the input register keeps taking
// one more transfer, then in_stall rises until the result moves on.
module i2c_bit_master (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [i2cbm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [i2cbm_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_cmd_valid,
  input  logic [2:0]                       in_func,
  input  logic [7:0]                       in_wr_data,
  input  logic                             in_sda_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_scl_out,
  output logic                             out_sda_out,
  output logic                             out_busy_res,
  output logic                             out_done_res,
  output logic [7:0]                       out_rd_data,
  output logic                             out_ack_ok
);

  i2cbm_pkg::item_t in_item;
  i2cbm_pkg::item_t item_r;
  i2cbm_pkg::res_t  res;
  i2cbm_pkg::res_t  res_r;
  logic             proc_en;
  logic             out_rdy;

  assign in_item.cmd_valid = in_cmd_valid;
  assign in_item.func      = in_func;
  assign in_item.wr_data   = in_wr_data;
  assign in_item.sda_in    = in_sda_in;

  i2cbm_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_rdy  (out_rdy),
    .proc_en  (proc_en),
    .item_r   (item_r)
  );

  i2cbm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .proc_en   (proc_en),
    .item      (item_r),
    .res       (res)
  );

  i2cbm_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .proc_en   (proc_en),
    .res       (res),
    .out_rdy   (out_rdy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_r     (res_r)
  );

  assign out_scl_out  = res_r.scl;
  assign out_sda_out  = res_r.sda;
  assign out_busy_res = res_r.busy;
  assign out_done_res = res_r.done;
  assign out_rd_data  = res_r.rd_data;
  assign out_ack_ok   = res_r.ack_ok;

endmodule

// ===== rtl/i2cbm_check.sv =====
module i2cbm_check (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             out_scl_out,
  input logic                             out_sda_out,
  input logic                             out_busy_res,
  input logic                             out_done_res,
  input logic [7:0]                       out_rd_data,
  input logic                             out_ack_ok
);

  // a finishing tick leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done reported while busy");

  // every command runs at least one busy tick, so done never repeats
  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_done_res |=> !(out_valid && out_done_res))
    else $error("done on two consecutive results");

  // read byte only changes on the tick a command finishes
  a_rd_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid && !out_stall) && (out_rd_data != $past(out_rd_data))
    |-> out_done_res)
    else $error("read byte changed without done");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_scl_out) && $stable(out_sda_out)
    && $stable(out_busy_res) && $stable(out_done_res) && $stable(out_rd_data)
    && $stable(out_ack_ok))
    else $error("stalled result changed");

endmodule

bind i2c_bit_master i2cbm_check u_i2cbm_check (.*);

// ===== sim/i2c_bit_master_test.sv =====
`timescale 1ns / 1ps

module i2c_bit_master_test;

  localparam logic [2:0] FN_NONE = 3'd7;

  // sda_in level fed while a command runs
  localparam logic [1:0] LINE_LOW  = 2'd0;
  localparam logic [1:0] LINE_HIGH = 2'd1;
  localparam logic [1:0] LINE_RAND = 2'd2;
  localparam logic [1:0] LINE_ACKY = 2'd3;

  localparam i2cbm_pkg::res_t IDLE_LINES  = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
  localparam i2cbm_pkg::res_t START_LINES = '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0};

  typedef struct packed {
    logic            cmd_valid;
    logic [2:0]      func;
    logic [7:0]      wr_data;
    logic            sda_in;
    logic [1:0]      line;
    logic            typed;
    i2cbm_pkg::res_t want;
  } dir_row_t;

  localparam int DIR_N = 19;
  // rows from here on run with a one-tick unit and a short ack timeout
  localparam int DIR_FAST_FROM = 3;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{1'b0, i2cbm_pkg::FN_READ,      8'hFF, 1'b1, LINE_RAND, 1'b1, IDLE_LINES},
    '{1'b1, FN_NONE,                 8'hFF, 1'b0, LINE_RAND, 1'b1, IDLE_LINES},
    '{1'b1, i2cbm_pkg::FN_START,     8'h00, 1'b1, LINE_RAND, 1'b1, START_LINES},
    '{1'b1, i2cbm_pkg::FN_WRITE,     8'hFF, 1'b0, LINE_RAND, 1'b0, '0},
    '{1'b1, i2cbm_pkg::FN_WAIT_ACK,  8'h00, 1'b1, LINE_LOW,  1'b0, '0},
    '{1'b1, i2cbm_pkg::FN_WRITE,     8'h00, 1'b1, LINE_RAND, 1'b0, '0},
    '{1'b1, i2cbm_pkg::FN_WAIT_ACK,  8'hFF, 1'b0, LINE_HIGH, 1'b0, '0},
    '{1'b1, i2cbm_pkg::FN_START,     8'h3C, 1'b0, LINE_RAND, 1'b0, '0},
    '{1'b1, i2cbm_pkg::FN_WRITE,     8'hA5, 1'b1, LINE_RAND, 1'b0, '0},
    '{1'b1, i2cbm_pkg::FN_WAIT_ACK,  8'h11, 1'b1, LINE_ACKY, 1'b0, '0},
    '{1'b1, i2cbm_pkg::FN_READ,      8'h00, 1'b0, LINE_HIGH, 1'b0, '0},
    '{1'b1, i2cbm_pkg::FN_SEND_ACK,  8'hFF, 1'b1, LINE_RAND, 1'b0, '0},
    '{1'b1, i2cbm_pkg::FN_READ,      8'hFF, 1'b1, LINE_LOW,  1'b0, '0},
    '{1'b1, i2cbm_pkg::FN_SEND_NACK, 8'h00, 1'b0, LINE_RAND, 1'b0, '0},
    '{1'b1, i2cbm_pkg::FN_READ,      8'h5A, 1'b1, LINE_RAND, 1'b0, '0},
    '{1'b1, i2cbm_pkg::FN_STOP,      8'hC3, 1'b0, LINE_RAND, 1'b0, '0},
    '{1'b1, i2cbm_pkg::FN_SEND_NACK, 8'h0F, 1'b1, LINE_RAND, 1'b0, '0},
    '{1'b1, i2cbm_pkg::FN_WRITE,     8'h5A, 1'b0, LINE_RAND, 1'b0, '0},
    '{1'b1, i2cbm_pkg::FN_STOP,      8'hF0, 1'b1, LINE_RAND, 1'b0, '0}
  };

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_wr_en;
  logic [i2cbm_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [i2cbm_pkg::CFG_W-1:0]     cfg_wdata;
  logic                            in_valid;
  logic                            in_stall;
  logic                            in_cmd_valid;
  logic [2:0]                      in_func;
  logic [7:0]                      in_wr_data;
  logic                            in_sda_in;
  logic                            out_valid;
  logic                            out_stall;
  logic                            out_scl_out;
  logic                            out_sda_out;
  logic                            out_busy_res;
  logic                            out_done_res;
  logic [7:0]                      out_rd_data;
  logic                            out_ack_ok;

  i2c_bit_master i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd_valid (in_cmd_valid),
    .in_func      (in_func),
    .in_wr_data   (in_wr_data),
    .in_sda_in    (in_sda_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_scl_out  (out_scl_out),
    .out_sda_out  (out_sda_out),
    .out_busy_res (out_busy_res),
    .out_done_res (out_done_res),
    .out_rd_data  (out_rd_data),
    .out_ack_ok   (out_ack_ok)
  );

  // bus state mirror
  logic [15:0] unit_cfg;
  logic [7:0]  tmo_cfg;
  logic [4:0]  seq_step;
  logic [15:0] unit_left;
  logic [3:0]  bits_done;
  logic [7:0]  shreg;
  logic [7:0]  polls_left;
  logic        scl_lv;
  logic        sda_lv;
  logic        ack_lv;
  logic        done_lv;
  logic [7:0]  rd_hold;

  i2cbm_pkg::res_t pending_lines [$];
  int   n_bad = 0;
  int   ticks_taken;
  int   cmds_issued;
  bit   calm;

  function automatic logic [15:0] eff_unit();
    return (unit_cfg == 16'd0) ? 16'd1 : unit_cfg;
  endfunction

  function automatic void seq_done();
    seq_step  = 5'd0;
    unit_left = 16'd0;
    done_lv   = 1'b1;
  endfunction

  // steps: 1-4 start, 5-10 stop, 11-14 write bit, 15-18 read bit,
  // 19-22 ack wait, 23-28 send ack, 29-30 send nack then 25-28
  function automatic void go_step(input logic [4:0] s, input logic sda);
    logic [4:0] tgt;
    logic       ended;
    tgt   = s;
    ended = 1'b0;
    case (s)
      5'd1: begin
        scl_lv = 1'b1;
        sda_lv = 1'b1;
      end
      5'd3, 5'd5, 5'd23: sda_lv = 1'b0;
      5'd7, 5'd13, 5'd21, 5'd25: scl_lv = 1'b1;
      5'd9, 5'd19, 5'd29: sda_lv = 1'b1;
      5'd11: begin
        scl_lv = 1'b0;
        sda_lv = shreg[7];
        shreg  = {shreg[6:0], 1'b0};
      end
      5'd15, 5'd20, 5'd27: scl_lv = 1'b0;
      5'd17: begin
        scl_lv = 1'b1;
        shreg  = {shreg[6:0], sda};
      end
      5'd22: begin
        if (!sda) begin
          scl_lv = 1'b0;
          ack_lv = 1'b1;
          seq_done();
          ended = 1'b1;
        end else begin
          if (polls_left != 8'd0) polls_left = polls_left - 8'd1;
          if (polls_left == 8'd0) begin
            ack_lv = 1'b0;
            sda_lv = 1'b0;
            tgt    = 5'd5;
          end
        end
      end
      default: ;
    endcase
    if (!ended) begin
      seq_step  = tgt;
      unit_left = eff_unit();
    end
  endfunction

  function automatic void unit_expired(input logic sda);
    case (seq_step)
      5'd4, 5'd10: seq_done();
      5'd14: begin
        bits_done = bits_done + 4'd1;
        if (bits_done >= 4'd8) begin
          scl_lv = 1'b0;
          seq_done();
        end else begin
          go_step(5'd11, sda);
        end
      end
      5'd18: begin
        bits_done = bits_done + 4'd1;
        if (bits_done >= 4'd8) begin
          scl_lv  = 1'b0;
          rd_hold = shreg;
          seq_done();
        end else begin
          go_step(5'd15, sda);
        end
      end
      5'd22: go_step(5'd22, sda);
      5'd28: begin
        sda_lv = 1'b1;
        seq_done();
      end
      5'd30: go_step(5'd25, sda);
      default: begin
        if (seq_step >= 5'd1 && seq_step < 5'd30) go_step(seq_step + 5'd1, sda);
        else seq_done();
      end
    endcase
  endfunction

  function automatic i2cbm_pkg::res_t bus_tick(input i2cbm_pkg::item_t it);
    i2cbm_pkg::res_t r;
    done_lv = 1'b0;
    if (seq_step == 5'd0) begin
      if (it.cmd_valid) begin
        case (it.func)
          i2cbm_pkg::FN_START: go_step(5'd1, it.sda_in);
          i2cbm_pkg::FN_STOP:  go_step(5'd5, it.sda_in);
          i2cbm_pkg::FN_WRITE: begin
            shreg     = it.wr_data;
            bits_done = 4'd0;
            go_step(5'd11, it.sda_in);
          end
          i2cbm_pkg::FN_READ: begin
            sda_lv    = 1'b1;
            shreg     = 8'd0;
            bits_done = 4'd0;
            go_step(5'd15, it.sda_in);
          end
          i2cbm_pkg::FN_WAIT_ACK: begin
            polls_left = (tmo_cfg == 8'd0) ? 8'd1 : tmo_cfg;
            go_step(5'd19, it.sda_in);
          end
          i2cbm_pkg::FN_SEND_ACK:  go_step(5'd23, it.sda_in);
          i2cbm_pkg::FN_SEND_NACK: go_step(5'd29, it.sda_in);
          default: ;
        endcase
      end
    end else begin
      if (unit_left != 16'd0) unit_left = unit_left - 16'd1;
      if (unit_left == 16'd0) unit_expired(it.sda_in);
    end
    r.scl     = scl_lv;
    r.sda     = sda_lv;
    r.busy    = (seq_step != 5'd0);
    r.done    = done_lv;
    r.rd_data = rd_hold;
    r.ack_ok  = ack_lv;
    return r;
  endfunction

  function automatic logic [1:0] ack_line();
    case ($urandom_range(3))
      0: return LINE_HIGH;
      1: return LINE_RAND;
      default: return LINE_ACKY;
    endcase
  endfunction

  task automatic put_tick(input i2cbm_pkg::item_t it, input logic typed,
                          input i2cbm_pkg::res_t want);
    i2cbm_pkg::res_t lines;
    while (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd_valid <= it.cmd_valid;
    in_func      <= it.func;
    in_wr_data   <= it.wr_data;
    in_sda_in    <= it.sda_in;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lines = bus_tick(it);
    pending_lines.push_back(typed ? want : lines);
    ticks_taken++;
  endtask

  task automatic fill_busy(input logic [1:0] line);
    i2cbm_pkg::item_t it;
    while (seq_step != 5'd0) begin
      it.cmd_valid = 1'($urandom_range(1));
      it.func      = 3'($urandom_range(7));
      it.wr_data   = 8'($urandom);
      case (line)
        LINE_LOW:  it.sda_in = 1'b0;
        LINE_HIGH: it.sda_in = 1'b1;
        LINE_ACKY: it.sda_in = ($urandom_range(7) != 0);
        default:   it.sda_in = 1'($urandom_range(1));
      endcase
      put_tick(it, 1'b0, '0);
    end
  endtask

  task automatic run_cmd(input logic [2:0] fn, input logic [7:0] wr, input logic [1:0] line);
    i2cbm_pkg::item_t it;
    repeat (($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0) begin
      it.cmd_valid = 1'b0;
      it.func      = 3'($urandom_range(7));
      it.wr_data   = 8'($urandom);
      it.sda_in    = 1'($urandom_range(1));
      put_tick(it, 1'b0, '0);
    end
    it.cmd_valid = 1'b1;
    it.func      = fn;
    it.wr_data   = wr;
    it.sda_in    = 1'($urandom_range(1));
    put_tick(it, 1'b0, '0);
    fill_busy(line);
    cmds_issued++;
  endtask

  task automatic random_phase(input int n_cmds);
    int stop_at;
    int n_body;
    stop_at = cmds_issued + n_cmds;
    while (cmds_issued < stop_at) begin
      if ($urandom_range(4) == 0) begin
        run_cmd(3'($urandom_range(7)), 8'($urandom), LINE_RAND);
      end else begin
        run_cmd(i2cbm_pkg::FN_START, 8'($urandom), LINE_RAND);
        run_cmd(i2cbm_pkg::FN_WRITE, 8'($urandom), LINE_RAND);
        run_cmd(i2cbm_pkg::FN_WAIT_ACK, 8'($urandom), ack_line());
        n_body = int'($urandom_range(3));
        repeat (n_body) begin
          if ($urandom_range(1) == 0) begin
            run_cmd(i2cbm_pkg::FN_WRITE, 8'($urandom), LINE_RAND);
            run_cmd(i2cbm_pkg::FN_WAIT_ACK, 8'($urandom), ack_line());
          end else begin
            run_cmd(i2cbm_pkg::FN_READ, 8'($urandom), LINE_RAND);
            run_cmd(($urandom_range(1) == 0) ? i2cbm_pkg::FN_SEND_ACK
                                             : i2cbm_pkg::FN_SEND_NACK,
                    8'($urandom), LINE_RAND);
          end
        end
        // occasionally leave the transfer open
        if ($urandom_range(7) != 0) run_cmd(i2cbm_pkg::FN_STOP, 8'($urandom), LINE_RAND);
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    for (int k = 0; k < 20000 && pending_lines.size() != 0; k++) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_bus_cfg(input logic [15:0] unit, input logic [7:0] tmo);
    logic [7:0] hi_byte;
    hi_byte = 8'($urandom);
    cfg_wr_en <= 1'b1;
    cfg_idx   <= i2cbm_pkg::CFG_UNIT_TICKS;
    cfg_wdata <= unit;
    @(posedge clk);
    unit_cfg = unit;
    cfg_idx   <= i2cbm_pkg::CFG_ACK_TIMEOUT;
    cfg_wdata <= {hi_byte, tmo};
    @(posedge clk);
    tmo_cfg = tmo;
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : rx_pace
    int  hold_left;
    bit  held;
    hold_left = 0;
    held      = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && ticks_taken >= 300) begin
        held      = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 15);
      end
    end
  end

  always @(posedge clk) begin : line_check
    i2cbm_pkg::res_t seen;
    i2cbm_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen.scl     = out_scl_out;
      seen.sda     = out_sda_out;
      seen.busy    = out_busy_res;
      seen.done    = out_done_res;
      seen.rd_data = out_rd_data;
      seen.ack_ok  = out_ack_ok;
      if (pending_lines.size() == 0) begin
        if (n_bad < 10) $display("unexpected result at %0t", $time);
        n_bad++;
      end else begin
        want = pending_lines.pop_front();
        if (seen !== want) begin
          if (n_bad < 10) begin
            $display("mismatch at %0t: want scl=%0b sda=%0b busy=%0b done=%0b rd=%02h ack=%0b",
                     $time, want.scl, want.sda, want.busy, want.done, want.rd_data,
                     want.ack_ok);
            $display("  got scl=%0b sda=%0b busy=%0b done=%0b rd=%02h ack=%0b",
                     seen.scl, seen.sda, seen.busy, seen.done, seen.rd_data, seen.ack_ok);
          end
          n_bad++;
        end
      end
    end
  end

  initial begin : stim
    i2cbm_pkg::item_t it;
    dir_row_t         row;
    ticks_taken  = 0;
    cmds_issued  = 0;
    calm         = 1'b0;
    unit_cfg     = i2cbm_pkg::UNIT_TICKS_RST;
    tmo_cfg      = i2cbm_pkg::ACK_TIMEOUT_RST;
    seq_step     = 5'd0;
    unit_left    = 16'd0;
    bits_done    = 4'd0;
    shreg        = 8'd0;
    polls_left   = 8'd0;
    scl_lv       = 1'b1;
    sda_lv       = 1'b1;
    ack_lv       = 1'b0;
    done_lv      = 1'b0;
    rd_hold      = 8'd0;
    rst_n        <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_idx      <= i2cbm_pkg::CFG_UNIT_TICKS;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    in_cmd_valid <= 1'b0;
    in_func      <= i2cbm_pkg::FN_START;
    in_wr_data   <= 8'd0;
    in_sda_in    <= 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      if (i == DIR_FAST_FROM) begin
        settle();
        set_bus_cfg(16'd1, 8'd3);
      end
      row          = DIR_ROWS[i];
      it.cmd_valid = row.cmd_valid;
      it.func      = row.func;
      it.wr_data   = row.wr_data;
      it.sda_in    = row.sda_in;
      put_tick(it, row.typed, row.want);
      fill_busy(row.line);
    end

    settle();
    set_bus_cfg(16'd1, 8'd1);
    random_phase(10);

    settle();
    set_bus_cfg(16'd0, 8'd0);
    random_phase(8);

    settle();
    set_bus_cfg(16'd2, 8'd7);
    calm = 1'b1;
    random_phase(6);
    calm = 1'b0;

    settle();
    if (n_bad == 0 && pending_lines.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/i2cbm_pkg.sv
rtl/i2cbm_in_stage.sv
rtl/i2cbm_seq.sv
rtl/i2cbm_out_stage.sv
rtl/i2c_bit_master.sv
rtl/i2cbm_check.sv
sim/i2c_bit_master_test.sv
